[hw/rtl/msb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_pkg
// shared constants, payload types and sequencer states of the sort buffer
// ----------------------------------------------------------------------------
package msb_pkg;

  localparam int MSB_CAPACITY = 64;
  localparam int DATA_W       = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_req_t;

  typedef enum logic [6:0] {
    ST_LOAD     = 7'b0000001,
    ST_SETUP    = 7'b0000010,
    ST_RD       = 7'b0000100,
    ST_CMP      = 7'b0001000,
    ST_OUT_RD   = 7'b0010000,
    ST_OUT_LD   = 7'b0100000,
    ST_OUT_WAIT = 7'b1000000
  } msb_state_t;

endpackage

[hw/rtl/merge_sort_buffer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_buffer_top
// collects a set of signed words and returns it sorted in ascending order
// ----------------------------------------------------------------------------
// Accepts one signed 32-bit value per input request until a request marked
// is_last, then sorts the held set (up to CAPACITY values) by bottom-up merge
// sort and returns it one value per output request, last_out on the final one.
// Values arriving while the buffer is full are dropped and every result of
// that set then reports overflow. Loading accepts one element per cycle. The
// sort makes ceil(log2 n) merge passes between two ping-pong stores; each
// merged element takes a store read, then a compare and write back, and each
// run pair adds one setup step. Each result is drained by a store read, an
// output register load and a request that waits for the output side. No input
// is taken while sorting or draining.
// ----------------------------------------------------------------------------
module merge_sort_buffer_top #(
  parameter int CAPACITY = msb_pkg::MSB_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msb_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output msb_pkg::out_req_t out_data
);
  import msb_pkg::*;

  // store address width; the counters are wide enough to hold the set size itself
  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // shared store port signals, write enables per store
  logic              we0, we1;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] m0_rdata_a, m0_rdata_b, m1_rdata_a, m1_rdata_b;

  // sequencer: load, merge passes, drain
  msb_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .we0        (we0),
    .we1        (we1),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .m0_rdata_a (m0_rdata_a),
    .m0_rdata_b (m0_rdata_b),
    .m1_rdata_a (m1_rdata_a),
    .m1_rdata_b (m1_rdata_b)
  );

  // data store: loaded elements and the results of even-numbered passes
  msb_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_data_store (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (m0_rdata_a),
    .rdata_b (m0_rdata_b)
  );

  // merge store: the other half of the ping-pong pair
  msb_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_merge_store (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (m1_rdata_a),
    .rdata_b (m1_rdata_b)
  );

endmodule

[hw/rtl/msb_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_mem
// element store: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module msb_mem #(
  parameter int DEPTH = msb_pkg::MSB_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [msb_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [msb_pkg::DATA_W-1:0] rdata_a,
  output logic [msb_pkg::DATA_W-1:0] rdata_b
);
  import msb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/msb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_ctrl
// load, bottom-up merge pass and drain sequencer over two ping-pong stores
// ----------------------------------------------------------------------------
module msb_ctrl #(
  parameter int CAPACITY = msb_pkg::MSB_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  msb_pkg::in_req_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output msb_pkg::out_req_t          out_data,
  output logic                       we0,
  output logic                       we1,
  output logic [AW-1:0]              waddr,
  output logic [msb_pkg::DATA_W-1:0] wdata,
  output logic [AW-1:0]              raddr_a,
  output logic [AW-1:0]              raddr_b,
  input  logic [msb_pkg::DATA_W-1:0] m0_rdata_a,
  input  logic [msb_pkg::DATA_W-1:0] m0_rdata_b,
  input  logic [msb_pkg::DATA_W-1:0] m1_rdata_a,
  input  logic [msb_pkg::DATA_W-1:0] m1_rdata_b
);
  import msb_pkg::*;

  localparam int XW = CNT_W + 2;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  msb_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             src_r, src_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_req_t         out_data_r, out_data_nxt;

  logic [DATA_W-1:0] rd_a, rd_b;
  logic [XW-1:0]     mid_sum, hi_sum, n_ext, w2;
  logic [CNT_W-1:0]  k_inc;
  logic              take_a, in_acc, out_acc;

  assign rd_a    = src_r ? m1_rdata_a : m0_rdata_a;
  assign rd_b    = src_r ? m1_rdata_b : m0_rdata_b;
  assign n_ext   = XW'(count_r);
  assign mid_sum = XW'(lo_r) + XW'(w_r);
  assign hi_sum  = XW'(lo_r) + (XW'(w_r) << 1);
  assign w2      = XW'(w_r) << 1;
  assign k_inc   = k_r + CNT_W'(1);
  assign take_a  = (i_r < mid_r) &&
                   ((j_r >= hi_r) || ($signed(rd_a) <= $signed(rd_b)));

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_acc   = out_valid_r && out_ready;

  // store ports
  always_comb begin
    we0     = 1'b0;
    we1     = 1'b0;
    waddr   = k_r[AW-1:0];
    wdata   = take_a ? rd_a : rd_b;
    raddr_a = i_r[AW-1:0];
    raddr_b = j_r[AW-1:0];
    if (state_r == ST_LOAD) begin
      we0   = in_acc && (count_r < CAP_C);
      waddr = count_r[AW-1:0];
      wdata = in_data.value;
    end else if (state_r == ST_CMP) begin
      we0 = src_r;
      we1 = !src_r;
    end
    if (state_r == ST_OUT_RD) begin
      raddr_a = k_r[AW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    src_nxt       = src_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < CAP_C) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_data.is_last) begin
            src_nxt = 1'b0;
            w_nxt   = CNT_W'(1);
            lo_nxt  = '0;
            k_nxt   = '0;
            // a single element needs no merge pass
            if (count_r == '0) begin
              state_nxt = ST_OUT_RD;
            end else begin
              state_nxt = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        mid_nxt   = (mid_sum > n_ext) ? count_r : mid_sum[CNT_W-1:0];
        hi_nxt    = (hi_sum > n_ext) ? count_r : hi_sum[CNT_W-1:0];
        i_nxt     = lo_r;
        j_nxt     = (mid_sum > n_ext) ? count_r : mid_sum[CNT_W-1:0];
        k_nxt     = lo_r;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        k_nxt = k_inc;
        if (take_a) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
        if (k_inc == hi_r) begin
          lo_nxt    = hi_r;
          state_nxt = ST_SETUP;
          if (hi_r == count_r) begin
            // pass complete: result now lives in the other store
            src_nxt = !src_r;
            lo_nxt  = '0;
            if (w2 >= n_ext) begin
              k_nxt     = '0;
              state_nxt = ST_OUT_RD;
            end else begin
              w_nxt = w2[CNT_W-1:0];
            end
          end
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_data_nxt.sorted_value = rd_a;
        out_data_nxt.last_out     = (k_inc == count_r);
        out_data_nxt.overflow     = dropped_r;
        out_valid_nxt             = 1'b1;
        state_nxt                 = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_inc;
          if (out_data_r.last_out) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            src_nxt     = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      src_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    lo_r       <= lo_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  // loading and draining never overlap
  a_no_load_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("input taken while a sorted request is pending");

  // only one store is written in any cycle
  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(we0 && we1))
    else $error("both stores written in one cycle");

  // a merge step always stays inside its run
  a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (k_r < hi_r && hi_r <= count_r))
    else $error("merge output index outside its run");

  // a result is only offered for a non-empty set
  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r != '0 && k_r < count_r))
    else $error("sorted request offered beyond the held set");

  // the store only fills while loading
  a_fill_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > $past(count_r)) |-> ($past(state_r) == ST_LOAD))
    else $error("element count grew outside loading");

endmodule

[bench/merge_sort_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_checker
// watches both request channels of the sort buffer and checks every result
// ----------------------------------------------------------------------------
// Keeps its own copy of the held set, sorts it by bottom-up merge passes when
// a request marked is_last is taken, and queues the sorted words. Each output
// request is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module merge_sort_checker #(
  parameter int CAPACITY = msb_pkg::MSB_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  msb_pkg::in_req_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  msb_pkg::out_req_t out_data,
  output int                results_pending,
  output int                error_count
);

  logic signed [msb_pkg::DATA_W-1:0] held_words  [CAPACITY];
  logic signed [msb_pkg::DATA_W-1:0] merge_words [CAPACITY];
  int                                held_count;
  logic                              dropped_seen;
  msb_pkg::out_req_t                 sorted_q [$];
  int                                mismatches;

  initial begin
    mismatches      = 0;
    held_count      = 0;
    dropped_seen    = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // bottom-up merge passes, left run wins ties
  function automatic void merge_sort_held(int n);
    int width;
    int lo;
    int mid;
    int hi;
    int i;
    int j;
    int k;
    for (width = 1; width < n; width = width * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * width) begin
        mid = (lo + width > n) ? n : lo + width;
        hi  = (lo + 2 * width > n) ? n : lo + 2 * width;
        i = lo;
        j = mid;
        k = lo;
        while (i < mid && j < hi) begin
          if (held_words[i] <= held_words[j]) begin
            merge_words[k] = held_words[i];
            i++;
          end else begin
            merge_words[k] = held_words[j];
            j++;
          end
          k++;
        end
        while (i < mid) begin
          merge_words[k] = held_words[i];
          i++;
          k++;
        end
        while (j < hi) begin
          merge_words[k] = held_words[j];
          j++;
          k++;
        end
      end
      for (lo = 0; lo < n; lo++) held_words[lo] = merge_words[lo];
    end
  endfunction

  task automatic absorb_word(msb_pkg::in_req_t req);
    msb_pkg::out_req_t res;
    int                k;
    if (held_count < CAPACITY) begin
      held_words[held_count] = req.value;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (req.is_last) begin
      merge_sort_held(held_count);
      for (k = 0; k < held_count; k++) begin
        res.sorted_value = held_words[k];
        res.last_out     = (k + 1 == held_count);
        res.overflow     = dropped_seen;
        sorted_q.push_back(res);
      end
      held_count   = 0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic check_result(msb_pkg::out_req_t res);
    msb_pkg::out_req_t want;
    if (sorted_q.size() == 0) begin
      report_mismatch("unexpected result", res.sorted_value, 32'd0);
    end else begin
      want = sorted_q.pop_front();
      if (res.sorted_value !== want.sorted_value)
        report_mismatch("sorted_value", res.sorted_value, want.sorted_value);
      if (res.last_out !== want.last_out)
        report_mismatch("last_out", 32'(res.last_out), 32'(want.last_out));
      if (res.overflow !== want.overflow)
        report_mismatch("overflow", 32'(res.overflow), 32'(want.overflow));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count   = 0;
      dropped_seen = 1'b0;
      sorted_q.delete();
    end else begin
      // results belong to an earlier set, so take them first
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) absorb_word(in_data);
    end
    results_pending <= sorted_q.size();
    error_count     <= mismatches;
  end

endmodule

[bench/merge_sort_buffer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_buffer_top_tb
// stimulus and verdict for the merge sort buffer
// ----------------------------------------------------------------------------
// Sends short hand-picked sets first (single element, extremes, ties,
// descending order), then a full set, an overflowing set and random sets of
// mostly small sizes. Both sides idle at random; once the receiver holds off
// for a long stretch so the block stalls its input. The checker beside the
// block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module merge_sort_buffer_top_tb;

  localparam int                 CAPACITY     = msb_pkg::MSB_CAPACITY;
  localparam logic signed [31:0] WORD_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX     = 32'sh7fff_ffff;
  localparam int                 RANDOM_ITEMS = 250;
  // keep a wide margin over the slowest run
  localparam int                 CYCLE_LIMIT  = 200000;
  localparam int                 DRAIN_CYCLES = 3000;
  localparam int                 HOLD_CYCLES  = 600;
  localparam int                 HOLD_AFTER   = 40;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  msb_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_ready;
  msb_pkg::out_req_t out_data;

  int results_pending;
  int error_count;
  int cycle_count;
  int items_sent;
  int results_taken;
  bit sender_burst;
  bit receiver_burst;

  merge_sort_buffer_top #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  merge_sort_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .results_pending (results_pending),
    .error_count     (error_count)
  );

  // 20 ns period
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run-away guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mix of extremes, a narrow band for ties and fully random words
  function automatic logic signed [31:0] pick_word();
    logic signed [31:0] w;
    case ($urandom_range(0, 9))
      0: begin
        w = WORD_MIN;
      end
      1: begin
        w = WORD_MAX;
      end
      2, 3, 4: begin
        w = $signed($urandom_range(0, 7)) - 4;
      end
      default: begin
        w = $urandom;
      end
    endcase
    return w;
  endfunction

  // one input request: optional idle gap, then hold valid until taken
  task automatic send_word(logic signed [31:0] w, logic last);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data.value    <= w;
    in_data.is_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_set(int n);
    int k;
    for (k = 0; k < n; k++) send_word(pick_word(), k == n - 1);
  endtask

  // receiver: random stalls, burst stretches, and one long hold-off
  initial begin
    int  wait_cycles;
    bit  held_once;
    out_ready      <= 1'b0;
    results_taken  = 0;
    receiver_burst = 1'b0;
    held_once      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken % 32 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      if (!held_once && results_taken == HOLD_AFTER) begin
        // sender keeps offering meanwhile, so the block holds a result and stalls its input
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        wait_cycles = receiver_burst ? 0 : $urandom_range(0, 14);
        if (wait_cycles > 0) begin
          out_ready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // stimulus and verdict
  initial begin
    int n;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    items_sent   = 0;
    sender_burst = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single element set
    send_word(WORD_MIN, 1'b1);
    // both extremes, reversed
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_MIN, 1'b1);
    // sign boundary around zero
    send_word(32'sd0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_MIN, 1'b1);
    // all equal
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b1);
    // duplicates in both halves of a merge
    send_word(32'sd3, 1'b0);
    send_word(-32'sd3, 1'b0);
    send_word(32'sd3, 1'b0);
    send_word(-32'sd3, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sd0, 1'b1);
    // strictly descending
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_MAX - 1, 1'b0);
    send_word(WORD_MIN + 1, 1'b0);
    send_word(WORD_MIN, 1'b1);

    // exactly full, then overflowing with the last request itself dropped
    sender_burst = 1'b0;
    send_random_set(CAPACITY);
    send_random_set(CAPACITY + 3);

    // random sets, mostly small, now and then around the capacity
    while (items_sent < RANDOM_ITEMS) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 4)
                                      : $urandom_range(1, 10);
      send_random_set(n);
    end
    in_valid <= 1'b0;

    // let the checker see the last request before judging the queue
    repeat (2) @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
